>>> design/rbd_pkg.sv
// Shared types and codes for the ring buffer deque.
package rbd_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_WRITE_AT   = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  position;
      logic [63:0] value_in;
   } req_item_type;

   typedef struct packed {
      logic [63:0] value_out;
      logic [1:0]  status;
      logic [9:0]  count;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic respond;
   } cmd_type;

endpackage

>>> design/rbd_ctrl.sv
// Request sequencer: accepts an item, then presents its result for one cycle.
module rbd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output rbd_pkg::cmd_type cmd
);
   import rbd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.respond = 1'b0;
      busy        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            busy        = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> design/rbd_dpath.sv
// Deque datapath: front index, item count, slot calculation and the store.
module rbd_dpath #(
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rbd_pkg::cmd_type      cmd,
   input  rbd_pkg::req_item_type req,
   output rbd_pkg::rsp_item_type rsp
);
   import rbd_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW:0]   DEPTH_W = (IW+1)'(DEPTH);
   localparam logic [IW-1:0] LAST_W  = IW'(DEPTH - 1);
   localparam logic [IW-1:0] HALF_W  = IW'(DEPTH / 2);

   logic [63:0]   mem [DEPTH];

   logic [IW-1:0] front_ff, front_in;
   logic [IW-1:0] count_ff, count_in;
   status_type    stat_ff, stat_in;
   logic          rd_ff;
   logic [63:0]   rdata_ff;

   logic          full, empty, in_range, wr, rd;
   logic [IW-1:0] base, offset, slot;
   logic [IW:0]   sum;

   always_comb begin
      full     = ({1'b0, count_ff} + (IW+1)'(1)) >= DEPTH_W;
      empty    = count_ff == '0;
      in_range = 32'(req.position) < 32'(count_ff);
      front_in = front_ff;
      count_in = count_ff;
      stat_in  = ST_OK;
      wr       = 1'b0;
      rd       = 1'b0;
      base     = front_ff;
      offset   = '0;
      case (req.req_type)
         OP_PUSH_BACK: begin
            if (full) begin
               stat_in = ST_FULL;
            end else begin
               offset   = count_ff;
               wr       = 1'b1;
               count_in = count_ff + IW'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               stat_in = ST_FULL;
            end else begin
               front_in = (front_ff == '0) ? LAST_W : front_ff - IW'(1);
               base     = front_in;
               wr       = 1'b1;
               count_in = count_ff + IW'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               stat_in = ST_EMPTY;
            end else begin
               offset   = count_ff - IW'(1);
               rd       = 1'b1;
               count_in = count_ff - IW'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               stat_in = ST_EMPTY;
            end else begin
               rd       = 1'b1;
               front_in = (front_ff == LAST_W) ? '0 : front_ff + IW'(1);
               count_in = count_ff - IW'(1);
            end
         end
         OP_READ_AT: begin
            if (!in_range) begin
               stat_in = ST_RANGE;
            end else begin
               offset = IW'(req.position);
               rd     = 1'b1;
            end
         end
         OP_WRITE_AT: begin
            if (!in_range) begin
               stat_in = ST_RANGE;
            end else begin
               offset = IW'(req.position);
               wr     = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            front_in = HALF_W;
         end
         default: begin
            stat_in = ST_OK;
         end
      endcase
      sum  = {1'b0, base} + {1'b0, offset};
      slot = (sum >= DEPTH_W) ? IW'(sum - DEPTH_W) : IW'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= HALF_W;
         count_ff <= '0;
      end else if (cmd.capture) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stat_ff <= stat_in;
         rd_ff   <= rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && wr) begin
         mem[slot] <= req.value_in;
      end
      if (cmd.capture && rd) begin
         rdata_ff <= mem[slot];
      end
   end

   always_comb begin
      rsp.value_out = (cmd.respond && rd_ff) ? rdata_ff : 64'd0;
      rsp.status    = stat_ff;
      rsp.count     = 10'(count_ff);
   end

endmodule

>>> design/ring_buffer_deque.sv
// Ring buffer deque top level: sequencer and datapath.
// An item accepted at one edge has its result strobed in the next cycle.
// A new item is accepted only while idle, not while the previous result is presented.
// Busy is high while a result is presented; the receiver cannot stall.
// Reset: queue empty, front index at half the depth; the store is not cleared.
module ring_buffer_deque #(
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rbd_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output rbd_pkg::rsp_item_type rsp_data
);
   import rbd_pkg::*;

   cmd_type cmd;

   rbd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   rbd_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .rsp   (rsp_data)
   );

   assign rsp_valid = cmd.respond;

   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted item produced no result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.value_out == 64'd0))
      else $error("failed request returned a nonzero value");

endmodule
